// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the blitter RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define BLIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition leads to a result on the next clock edge
`define BLIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bmpblit_pkg.sv -----
// Shared types and constants of the BMP framebuffer blitter
package bmpblit_pkg;

    localparam int SCREEN_W      = 800;
    localparam int SCREEN_H      = 480;
    localparam int MAX_IMAGE_DIM = 4096;

    // Widths of an on-screen column and row
    localparam int SX_W = $clog2(SCREEN_W + 1);
    localparam int SY_W = $clog2(SCREEN_H + 1);

    // Fixed field widths
    localparam int DIM_W   = 13;
    localparam int CNT_W   = 12;
    localparam int COLOR_W = 24;
    localparam int ADDR_W  = 19;

    // Depth of the pixel queue and of the output buffer (power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEST_X       = 2'd0,
        CFG_DEST_Y       = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_idx;

    // Clamped configuration seen by the datapath
    typedef struct packed {
        logic signed [DIM_W-1:0] dest_x;
        logic signed [DIM_W-1:0] dest_y;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
    } t_cfg;

    // One assembled pixel with its stored position
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   col;
        logic [CNT_W-1:0]   row;
        logic               last;
    } t_pix;

    // One framebuffer write
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               on_screen;
        logic               last;
    } t_res;

    // Force an image dimension into 1..MAX_IMAGE_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0) begin
                r = DIM_W'(1);
            end else if (v > DIM_W'(MAX_IMAGE_DIM)) begin
                r = DIM_W'(MAX_IMAGE_DIM);
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// ----- rtl/bmp24_to_framebuffer_blit.sv -----
// Top level of the 24-bit bottom-up BMP to framebuffer blitter
// Takes the pixel-array bytes of a 24-bit bottom-up BMP, padding included, at
// one byte per cycle while full is low, and gives one framebuffer write per
// three data bytes: word address, 0xRRGGBB color, an on-screen flag
// (off-screen pixels carry address 0) and a flag on the image's last pixel.
// A pixel result is registered in the pixel queue and then in the output
// buffer before it reaches the output ports. The byte assembler feeds a
// two-entry pixel queue, and the address stage (one constant multiply)
// fills a two-entry output buffer; full rises only when both have filled under
// a stalled pop. Width and height written as 0 act as 1, above 4096 as 4096.
// Configuration must be written only while no image is in flight; the block
// itself does not enforce this. There is no clearing pass after reset.
module bmp24_to_framebuffer_blit
    import bmpblit_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_pixel_byte,
    output logic               empty,
    input  logic               pop,
    output logic [ADDR_W-1:0]  o_pixel_address,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_on_screen,
    output logic               o_last_pixel
);

    logic signed [DIM_W-1:0] r_dest_x;
    logic signed [DIM_W-1:0] r_dest_y;
    logic [DIM_W-1:0]        r_width;
    logic [DIM_W-1:0]        r_height;

    t_cfg cfg;
    logic px_valid;
    t_pix px_in;
    logic px_full;
    logic px_empty;
    t_pix px_out;
    logic px_pop;
    t_res res;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x <= '0;
            r_dest_y <= '0;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEST_X:       r_dest_x <= $signed(i_cfg_data);
                CFG_DEST_Y:       r_dest_y <= $signed(i_cfg_data);
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp image size
    assign cfg.dest_x = r_dest_x;
    assign cfg.dest_y = r_dest_y;
    assign cfg.width  = clamp_dim(r_width);
    assign cfg.height = clamp_dim(r_height);

    assign full = px_full;

    bmpblit_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_byte     (i_pixel_byte),
        .i_px_full  (px_full),
        .o_px_valid (px_valid),
        .o_px       (px_in)
    );

    bmpblit_pxq u_pxq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (px_valid),
        .i_data  (px_in),
        .i_pop   (px_pop),
        .o_full  (px_full),
        .o_empty (px_empty),
        .o_data  (px_out)
    );

    bmpblit_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_px_empty (px_empty),
        .i_px       (px_out),
        .o_px_pop   (px_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_pixel_address = res.addr;
    assign o_pixel_color   = res.color;
    assign o_on_screen     = res.on_screen;
    assign o_last_pixel    = res.last;

endmodule

// ----- rtl/bmpblit_front.sv -----
// Byte assembler and row/column counters of the blitter
module bmpblit_front
    import bmpblit_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_push,
    input  logic [7:0] i_byte,
    input  logic       i_px_full,
    output logic       o_px_valid,
    output t_pix       o_px
);

    logic [1:0]       r_phase, n_phase;
    logic [15:0]      r_partial, n_partial;
    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic [1:0]       r_pad, n_pad;

    logic             accept;
    logic             end_row;
    logic             end_img;
    logic [1:0]       w3_mod4;

    assign accept  = i_push && !i_px_full;
    assign end_row = ({1'b0, r_col} + DIM_W'(1)) >= i_cfg.width;
    assign end_img = end_row && (({1'b0, r_row} + DIM_W'(1)) >= i_cfg.height);
    // 3*width mod 4 from the two low bits of width
    assign w3_mod4 = i_cfg.width[1:0] + {i_cfg.width[0], 1'b0};

    // Emit a pixel on the third data byte
    assign o_px_valid = accept && (r_phase == 2'd2);
    assign o_px.color = {i_byte, r_partial};
    assign o_px.col   = r_col;
    assign o_px.row   = r_row;
    assign o_px.last  = end_img;

    // Step the byte phase, skip padding, advance counters
    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        n_col     = r_col;
        n_row     = r_row;
        n_pad     = r_pad;
        if (accept) begin
            if (r_phase == 2'd0 && r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else if (r_phase == 2'd0) begin
                n_partial = {8'd0, i_byte};
                n_phase   = 2'd1;
            end else if (r_phase == 2'd1) begin
                n_partial = {i_byte, r_partial[7:0]};
                n_phase   = 2'd2;
            end else begin
                n_phase   = 2'd0;
                n_partial = '0;
                if (end_row) begin
                    n_col = '0;
                    n_pad = 2'd0 - w3_mod4;
                    n_row = end_img ? '0 : r_row + CNT_W'(1);
                end else begin
                    n_col = r_col + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 2'd0;
            r_partial <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_pad     <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_col     <= n_col;
            r_row     <= n_row;
            r_pad     <= n_pad;
        end
    end

`include "assert_macros.svh"
    `BLIT_ASSERT(a_pad_only_between_pixels, (r_pad == 2'd0) || (r_phase == 2'd0), "padding mid-pixel")
    `BLIT_ASSERT_NEXT(a_pixel_closes_phase, o_px_valid, r_phase == 2'd0, "phase not closed")

endmodule

// ----- rtl/bmpblit_pxq.sv -----
// Short pixel queue between the assembler and the address stage
module bmpblit_pxq
    import bmpblit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_pix o_data
);

    t_pix              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    // Store pixels
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`include "assert_macros.svh"
    `BLIT_ASSERT(a_pxq_level, r_cnt <= QCNT_W'(QDEPTH), "pixel queue overfilled")

endmodule

// ----- rtl/bmpblit_back.sv -----
// Screen position, clipping, address and output buffer of the blitter
module bmpblit_back
    import bmpblit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_px_empty,
    input  t_pix i_px,
    output logic o_px_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    t_res              r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    logic signed [DIM_W:0]   sx;
    logic signed [DIM_W+1:0] sy;
    logic                    vis;
    logic [ADDR_W-1:0]       addr;
    t_res                    res;
    logic                    buf_full;
    logic                    do_pop;

    // Place the pixel on the screen, bottom-up rows flipped
    always_comb begin
        sx  = $signed({i_cfg.dest_x[DIM_W-1], i_cfg.dest_x})
            + $signed({2'b00, i_px.col});
        sy  = $signed({{2{i_cfg.dest_y[DIM_W-1]}}, i_cfg.dest_y})
            + $signed({2'b00, i_cfg.height})
            - $signed((DIM_W + 2)'(1))
            - $signed({3'b000, i_px.row});
        vis = (sx >= 0) && (sx < $signed((DIM_W + 1)'(SCREEN_W)))
           && (sy >= 0) && (sy < $signed((DIM_W + 2)'(SCREEN_H)));
        addr = ADDR_W'(sx[SX_W-1:0]) + ADDR_W'(sy[SY_W-1:0]) * ADDR_W'(SCREEN_W);
        res.addr      = vis ? addr : '0;
        res.color     = i_px.color;
        res.on_screen = vis;
        res.last      = i_px.last;
    end

    assign buf_full = (r_cnt == QCNT_W'(QDEPTH));
    assign o_px_pop = !i_px_empty && !buf_full;
    assign o_empty  = (r_cnt == '0);
    assign o_res    = r_buf[r_rptr];
    assign do_pop   = i_pop && !o_empty;

    // Track output buffer pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (o_px_pop) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(o_px_pop) - QCNT_W'(do_pop);
        end
    end

    // Hold finished results
    always_ff @(posedge i_clk) begin
        if (o_px_pop) begin
            r_buf[r_wptr] <= res;
        end
    end

`include "assert_macros.svh"
    `BLIT_ASSERT(a_addr_in_screen, o_empty || !o_res.on_screen || (o_res.addr < ADDR_W'(SCREEN_W * SCREEN_H)), "visible address off screen")

endmodule

// ----- dv/bmp24_to_framebuffer_blit_test.sv -----
// Self-checking testbench for the 24-bit bottom-up BMP to framebuffer blitter
module bmp24_to_framebuffer_blit_test;
    import bmpblit_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_BYTES   = 45;
    localparam int HOLD_PHASE    = 5;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_wr_en  = 1'b0;
    logic [1:0]         i_cfg_index  = CFG_DEST_X;
    logic [DIM_W-1:0]   i_cfg_data   = '0;
    logic               push         = 1'b0;
    logic [7:0]         i_pixel_byte = '0;
    logic               pop          = 1'b0;
    logic               full;
    logic               empty;
    logic [ADDR_W-1:0]  o_pixel_address;
    logic [COLOR_W-1:0] o_pixel_color;
    logic               o_on_screen;
    logic               o_last_pixel;

    // Bytes waiting to be pushed and framebuffer writes waiting to come out
    logic [7:0] pending_bytes[$];
    t_res       expected_writes[$];

    // Idle control, set by the sequencer at falling edges
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_send      = 1'b0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    // Shadow registers and stream state of the blitter
    logic signed [DIM_W-1:0] cfg_dest_x = '0;
    logic signed [DIM_W-1:0] cfg_dest_y = '0;
    logic [DIM_W-1:0]        cfg_width  = DIM_W'(1);
    logic [DIM_W-1:0]        cfg_height = DIM_W'(1);
    logic [1:0]              byte_phase = '0;
    logic [15:0]             color_lo   = '0;
    logic [CNT_W-1:0]        col_cnt    = '0;
    logic [CNT_W-1:0]        row_cnt    = '0;
    logic [1:0]              pad_left   = '0;

    bmp24_to_framebuffer_blit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_pixel_byte    (i_pixel_byte),
        .empty           (empty),
        .pop             (pop),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_on_screen     (o_on_screen),
        .o_last_pixel    (o_last_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Effective image dimension: zero acts as one, oversize saturates
    function automatic int fit_dim(logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_IMAGE_DIM) return MAX_IMAGE_DIM;
        return int'(v);
    endfunction

    function automatic int row_pad(int w);
        return (4 - ((3 * w) & 3)) & 3;
    endfunction

    // Advance the stream state by one byte; queue a framebuffer write per pixel
    function automatic void predict_byte(logic [7:0] b);
        int   w;
        int   h;
        int   sx;
        int   sy;
        logic end_row;
        logic end_img;
        logic vis;
        t_res wr;
        w = fit_dim(cfg_width);
        h = fit_dim(cfg_height);
        if (byte_phase == 2'd0 && pad_left != 2'd0) begin
            pad_left = pad_left - 2'd1;
            return;
        end
        if (byte_phase == 2'd0) begin
            color_lo   = {8'h00, b};
            byte_phase = 2'd1;
            return;
        end
        if (byte_phase == 2'd1) begin
            color_lo[15:8] = b;
            byte_phase     = 2'd2;
            return;
        end
        end_row = (int'(col_cnt) + 1 >= w);
        end_img = end_row && (int'(row_cnt) + 1 >= h);
        // bottom-up storage: stored row 0 lands on the lowest screen row
        sx  = int'(cfg_dest_x) + int'(col_cnt);
        sy  = int'(cfg_dest_y) + h - 1 - int'(row_cnt);
        vis = (sx >= 0) && (sx < SCREEN_W) && (sy >= 0) && (sy < SCREEN_H);
        wr.addr      = vis ? ADDR_W'(sx + SCREEN_W * sy) : '0;
        wr.color     = {b, color_lo};
        wr.on_screen = vis;
        wr.last      = end_img;
        expected_writes.push_back(wr);
        byte_phase = 2'd0;
        color_lo   = '0;
        if (end_row) begin
            col_cnt  = '0;
            pad_left = 2'(row_pad(w));
            row_cnt  = end_img ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    // Drive bytes from the pending queue, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_byte(pending_bytes.pop_front());
            end
            if (pending_bytes.size() != 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
                push         <= 1'b1;
                i_pixel_byte <= pending_bytes[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Check each popped write against the oldest expectation, stalling at random
    always @(posedge i_clk) begin
        t_res exp_wr;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected write: address %0d color %06h",
                           o_pixel_address, o_pixel_color);
                    mismatch_count++;
                end else begin
                    exp_wr = expected_writes.pop_front();
                    if (o_pixel_address !== exp_wr.addr) begin
                        $error("pixel_address: expected %0d, got %0d",
                               exp_wr.addr, o_pixel_address);
                        mismatch_count++;
                    end
                    if (o_pixel_color !== exp_wr.color) begin
                        $error("pixel_color: expected %06h, got %06h",
                               exp_wr.color, o_pixel_color);
                        mismatch_count++;
                    end
                    if (o_on_screen !== exp_wr.on_screen) begin
                        $error("on_screen: expected %0b, got %0b",
                               exp_wr.on_screen, o_on_screen);
                        mismatch_count++;
                    end
                    if (o_last_pixel !== exp_wr.last) begin
                        $error("last_pixel: expected %0b, got %0b",
                               exp_wr.last, o_last_pixel);
                        mismatch_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || i_cfg_wr_en) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Write one register; the shadow copy follows at once since the block is idle
    task automatic write_reg(t_cfg_idx idx, logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_DEST_X:       cfg_dest_x = val;
            CFG_DEST_Y:       cfg_dest_y = val;
            CFG_IMAGE_WIDTH:  cfg_width  = val;
            CFG_IMAGE_HEIGHT: cfg_height = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold until every byte is taken and every write has come out, then settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || push || expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_origin(int span);
        int r;
        r = $urandom_range(99);
        if (r < 65) return DIM_W'(int'($urandom_range(0, span + 16)) - 8);
        if (r < 75) return DIM_W'(-4096);
        if (r < 85) return DIM_W'(4095);
        return DIM_W'($urandom);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 80) return DIM_W'($urandom_range(1, 6));
        if (r < 88) return DIM_W'($urandom_range(7, 40));
        if (r < 92) return '0;
        if (r < 96) return DIM_W'(MAX_IMAGE_DIM);
        return DIM_W'($urandom_range(MAX_IMAGE_DIM + 1, 8191));
    endfunction

    // Mostly whole images of the current size, some short runs of stray bytes
    task automatic queue_random_bytes(int budget);
        int added;
        int img_len;
        int n;
        added   = 0;
        img_len = fit_dim(cfg_height) *
                  (3 * fit_dim(cfg_width) + row_pad(fit_dim(cfg_width)));
        while (added < budget) begin
            if ($urandom_range(99) < 85 && img_len <= 150) begin
                n = img_len;
            end else begin
                n = $urandom_range(1, 12);
            end
            repeat (n) pending_bytes.push_back(8'($urandom_range(0, 255)));
            added += n;
        end
    endtask

    initial begin
        int half;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset size 1x1 at the origin: one pixel, one pad byte
        pending_bytes = {8'hFF, 8'h00, 8'hFF, 8'h55};
        wait_drained();

        // 2x2 straddling the right and top edges: one pixel visible
        write_reg(CFG_DEST_X, DIM_W'(SCREEN_W - 1));
        write_reg(CFG_DEST_Y, DIM_W'(-1));
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(2));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(2));
        end_writes();
        pending_bytes = {8'h00, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'hA5, 8'h5A,
                         8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
        wait_drained();

        // Extreme origin, oversize width, zero height; stop two pixels in
        write_reg(CFG_DEST_X, DIM_W'(-4096));
        write_reg(CFG_DEST_Y, DIM_W'(4095));
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(8191));
        write_reg(CFG_IMAGE_HEIGHT, '0);
        end_writes();
        pending_bytes = {8'hC3, 8'h3C, 8'h99, 8'h66, 8'hE7, 8'h18};
        wait_drained();

        // Shrink the width mid-image: the column count ends the row and image
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(1));
        end_writes();
        pending_bytes = {8'h7E, 8'h81, 8'hDB, 8'h24};
        wait_drained();

        // Random phases, cycling through the idle patterns
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            write_reg(CFG_DEST_X, pick_origin(SCREEN_W));
            write_reg(CFG_DEST_Y, pick_origin(SCREEN_H));
            write_reg(CFG_IMAGE_WIDTH, pick_dim());
            write_reg(CFG_IMAGE_HEIGHT, pick_dim());
            end_writes();
            queue_random_bytes(PHASE_BYTES);
            if (p == HOLD_PHASE) begin
                // Pause the sender midway until every write has drained
                half = pending_bytes.size() / 2;
                do @(negedge i_clk);
                while (pending_bytes.size() > half);
                hold_send = 1'b1;
                do @(negedge i_clk);
                while (push || expected_writes.size() != 0);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_writes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
